// File: hw/rtl/cfp_pkg.sv
package cfp_pkg;

  typedef logic [31:0] word_t;
  typedef logic [15:0][31:0] block_t;

  // control of the shared round unit
  typedef struct packed {
    logic diag;         // diagonal round when set, column round otherwise
    logic second_half;  // second half of the quarter round (rotates 8 and 7)
  } round_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COPY,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } fsm_t;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 64;

  localparam logic [CFG_INDEX_W-1:0] REG_KEY_PART_0          = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_PART_1          = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_PART_2          = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_PART_3          = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_NONCE_LOW           = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_COUNTER_NONCE_HIGH  = 3'd5;

  localparam logic [1:0] ACT_RESEED = 2'd0;
  localparam logic [1:0] ACT_MIX    = 2'd1;
  localparam logic [1:0] ACT_DRAW   = 2'd2;

  localparam word_t CHACHA_CONST [4] = '{
    32'h61707865, 32'h3320646e, 32'h79622d32, 32'h6b206574
  };

  function automatic word_t rotl(input word_t v, input int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  // word index of a quarter-round operand: row picks a/b/c/d, diagonal shifts the column
  function automatic logic [3:0] qr_index(input logic [1:0] q, input logic [1:0] row,
                                          input logic diag);
    logic [1:0] col;
    col = diag ? 2'(q + row) : q;
    return {row, col};
  endfunction

endpackage

// File: hw/rtl/cfp_round.sv
module cfp_round
  import cfp_pkg::*;
(
  input  block_t      work,
  input  round_ctrl_t ctrl,
  output block_t      work_next
);

  logic [3:0] ia [4];
  logic [3:0] ib [4];
  logic [3:0] ic [4];
  logic [3:0] id [4];
  word_t      a1 [4];
  word_t      b1 [4];
  word_t      c1 [4];
  word_t      d1 [4];

  // four independent half quarter rounds per cycle
  always_comb begin
    work_next = work;
    for (int q = 0; q < 4; q++) begin
      ia[q] = qr_index(2'(q), 2'd0, ctrl.diag);
      ib[q] = qr_index(2'(q), 2'd1, ctrl.diag);
      ic[q] = qr_index(2'(q), 2'd2, ctrl.diag);
      id[q] = qr_index(2'(q), 2'd3, ctrl.diag);
      a1[q] = work[ia[q]] + work[ib[q]];
      d1[q] = ctrl.second_half ? rotl(work[id[q]] ^ a1[q], 8)
                               : rotl(work[id[q]] ^ a1[q], 16);
      c1[q] = work[ic[q]] + d1[q];
      b1[q] = ctrl.second_half ? rotl(work[ib[q]] ^ c1[q], 7)
                               : rotl(work[ib[q]] ^ c1[q], 12);
      work_next[ia[q]] = a1[q];
      work_next[ib[q]] = b1[q];
      work_next[ic[q]] = c1[q];
      work_next[id[q]] = d1[q];
    end
  end

endmodule

// File: hw/rtl/chacha_feedback_prng_core.sv
// chacha-feedback random word generator, one item at a time
// a mix without stir updates its state word as it is taken; a draw without stir
// passes the emit state, which waits for a free output register; a stir (every reseed,
// every MIX_SLOTS or last mix word, every fourth draw) runs the copy, round and add
// states, one half quarter-round step of the shared round unit per cycle; input stalls until idle
// reset: synchronous, clears state words, positions, registers and output valid
module chacha_feedback_prng_core
  import cfp_pkg::*;
#(
  parameter int unsigned DOUBLE_ROUNDS = 20,
  parameter int unsigned MIX_SLOTS     = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  // configuration write port
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // input items
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             action,
  input  logic [31:0]            data_word,
  input  logic                   last_word,
  // result items
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [31:0]            random_word
);

  // four steps per double round: column first half, column second half, diagonal halves
  localparam int unsigned ROUND_STEPS = 4 * DOUBLE_ROUNDS;
  localparam int unsigned STEP_W      = $clog2(ROUND_STEPS);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(ROUND_STEPS - 1);
  localparam logic [3:0]        MIX_LIMIT = 4'(MIX_SLOTS);

  // configuration registers
  logic [63:0] key_part [4];
  logic [63:0] nonce_low;
  logic [63:0] counter_and_nonce_high;

  // generator state
  block_t      state;
  block_t      work;
  block_t      work_next;
  logic [2:0]  mix_pos;
  logic [1:0]  draw_pos;
  logic [STEP_W-1:0] step;
  logic        emit_pending;

  fsm_t        fsm;
  fsm_t        fsm_next;

  round_ctrl_t round_ctrl;

  logic        accept;
  logic        out_free;
  logic [3:0]  mix_slot;
  logic        mix_wrap;
  logic        draw_wrap;
  logic [2:0]  mix_pos_inc;
  logic [1:0]  draw_pos_inc;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // mix bookkeeping: slot to xor into, and whether this word closes the batch
  assign mix_slot     = {1'b0, mix_pos} + 4'd4;
  assign mix_pos_inc  = mix_pos + 3'd1;
  assign mix_wrap     = (({1'b0, mix_pos} + 4'd1) >= MIX_LIMIT) || last_word;
  assign draw_pos_inc = draw_pos + 2'd1;
  assign draw_wrap    = (draw_pos == 2'd3);

  // shared round unit: step[0] picks the half, step[1] the diagonal round
  assign round_ctrl.second_half = step[0];
  assign round_ctrl.diag        = step[1];

  cfp_round u_round (
    .work      (work),
    .ctrl      (round_ctrl),
    .work_next (work_next)
  );

  // configuration writes, out-of-range index ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) key_part[i] <= '0;
      nonce_low              <= '0;
      counter_and_nonce_high <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_KEY_PART_0:         key_part[0]            <= cfg_data;
        REG_KEY_PART_1:         key_part[1]            <= cfg_data;
        REG_KEY_PART_2:         key_part[2]            <= cfg_data;
        REG_KEY_PART_3:         key_part[3]            <= cfg_data;
        REG_NONCE_LOW:          nonce_low              <= cfg_data;
        REG_COUNTER_NONCE_HIGH: counter_and_nonce_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    fsm_next = fsm;
    unique case (fsm)
      ST_IDLE: begin
        if (accept) begin
          unique case (action)
            ACT_RESEED: fsm_next = ST_COPY;
            ACT_MIX:    fsm_next = mix_wrap ? ST_COPY : ST_IDLE;
            ACT_DRAW:   fsm_next = draw_wrap ? ST_COPY : ST_EMIT;
            default:    fsm_next = ST_IDLE;
          endcase
        end
      end
      ST_COPY:  fsm_next = ST_ROUND;
      ST_ROUND: fsm_next = (step == LAST_STEP) ? ST_ADD : ST_ROUND;
      ST_ADD:   fsm_next = emit_pending ? ST_EMIT : ST_IDLE;
      ST_EMIT:  fsm_next = out_free ? ST_IDLE : ST_EMIT;
      default:  fsm_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    unique case (fsm)
      ST_IDLE: in_stall = 1'b0;
      default: in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm <= ST_IDLE;
    end else begin
      fsm <= fsm_next;
    end
  end

  // state words, positions and the draw flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= '0;
      mix_pos      <= '0;
      draw_pos     <= '0;
      emit_pending <= 1'b0;
    end else if (accept) begin
      emit_pending <= (action == ACT_DRAW);
      unique case (action)
        ACT_RESEED: begin
          for (int i = 0; i < 4; i++) state[i] <= CHACHA_CONST[i];
          for (int i = 0; i < 4; i++) begin
            state[4 + 2*i]     <= key_part[i][31:0];
            state[4 + 2*i + 1] <= key_part[i][63:32];
          end
          state[12] <= counter_and_nonce_high[31:0];
          state[13] <= nonce_low[31:0];
          state[14] <= nonce_low[63:32];
          state[15] <= counter_and_nonce_high[63:32];
          // a partial batch is dropped
          mix_pos   <= '0;
        end
        ACT_MIX: begin
          state[mix_slot] <= state[mix_slot] ^ data_word;
          mix_pos         <= mix_wrap ? 3'd0 : mix_pos_inc;
        end
        ACT_DRAW: begin
          draw_pos <= draw_pos_inc;
        end
        default: ;
      endcase
    end else if (fsm == ST_ADD) begin
      // feed-forward of the rounds into the state
      for (int i = 0; i < 16; i++) state[i] <= state[i] + work[i];
    end
  end

  // working copy and step counter for the rounds
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (fsm == ST_COPY) begin
      step <= '0;
    end else if (fsm == ST_ROUND) begin
      step <= step + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (fsm == ST_COPY) begin
      work <= state;
    end else if (fsm == ST_ROUND) begin
      work <= work_next;
    end
  end

  // output register, loaded once the slot is free
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fsm == ST_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fsm == ST_EMIT && out_free) begin
      random_word <= state[{2'b00, draw_pos}];
    end
  end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import cfp_pkg::*;

  localparam int unsigned DOUBLE_ROUNDS = 20;
  localparam int unsigned MIX_SLOTS     = 8;

  // action code the block has no use for
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // register indexes past the last register, writes there are dropped
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_6 = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_7 = 3'd7;

  // long enough for a trailing stir to finish, with some margin
  localparam int SETTLE_CYCLES = 4 * DOUBLE_ROUNDS + 40;
  localparam int DRAIN_LIMIT   = 50000;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_wr_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   in_valid;
  logic                   in_stall;
  logic [1:0]             action;
  logic [31:0]            data_word;
  logic                   last_word;
  logic                   out_valid;
  logic                   out_stall;
  logic [31:0]            random_word;

  // shadow of the generator: register copies, the 16-word block, both positions
  logic [63:0] seed_regs [6];
  block_t      model_block;
  logic [2:0]  model_mix_slot;
  logic [1:0]  model_draw_slot;

  // random words still owed by the block, oldest first
  word_t drawn_words_due [$];
  int    mismatch_count = 0;

  // when set, neither side idles or stalls
  logic quiet = 1'b0;

  chacha_feedback_prng_core #(
    .DOUBLE_ROUNDS(DOUBLE_ROUNDS),
    .MIX_SLOTS    (MIX_SLOTS)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .action     (action),
    .data_word  (data_word),
    .last_word  (last_word),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .random_word(random_word)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // generator shadow
  // ---------------------------------------------------------------------------

  function automatic word_t rot_left(input word_t v, input int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic block_t quarter_round(input block_t w, input int a, input int b,
                                           input int c, input int d);
    w[a] = w[a] + w[b]; w[d] = rot_left(w[d] ^ w[a], 16);
    w[c] = w[c] + w[d]; w[b] = rot_left(w[b] ^ w[c], 12);
    w[a] = w[a] + w[b]; w[d] = rot_left(w[d] ^ w[a], 8);
    w[c] = w[c] + w[d]; w[b] = rot_left(w[b] ^ w[c], 7);
    return w;
  endfunction

  // double rounds on a copy, then the copy is added back word by word
  function automatic block_t chacha_stir(input block_t s);
    block_t w;
    w = s;
    for (int r = 0; r < DOUBLE_ROUNDS; r++) begin
      // columns
      w = quarter_round(w, 0, 4, 8, 12);
      w = quarter_round(w, 1, 5, 9, 13);
      w = quarter_round(w, 2, 6, 10, 14);
      w = quarter_round(w, 3, 7, 11, 15);
      // diagonals
      w = quarter_round(w, 0, 5, 10, 15);
      w = quarter_round(w, 1, 6, 11, 12);
      w = quarter_round(w, 2, 7, 8, 13);
      w = quarter_round(w, 3, 4, 9, 14);
    end
    for (int i = 0; i < 16; i++) w[i] = w[i] + s[i];
    return w;
  endfunction

  // advance the shadow by one accepted item, queue the word a draw must return
  function automatic void apply_item(input logic [1:0] act, input word_t dw, input logic lw);
    logic [3:0] key_slot;
    key_slot = 4'd4 + {1'b0, model_mix_slot};
    case (act)
      ACT_RESEED: begin
        for (int i = 0; i < 4; i++) model_block[i] = CHACHA_CONST[i];
        for (int k = 0; k < 4; k++) begin
          model_block[4 + 2 * k] = seed_regs[k][31:0];
          model_block[5 + 2 * k] = seed_regs[k][63:32];
        end
        model_block[12] = seed_regs[REG_COUNTER_NONCE_HIGH][31:0];
        model_block[13] = seed_regs[REG_NONCE_LOW][31:0];
        model_block[14] = seed_regs[REG_NONCE_LOW][63:32];
        model_block[15] = seed_regs[REG_COUNTER_NONCE_HIGH][63:32];
        // a half-filled entropy batch is thrown away, the draw position stays
        model_mix_slot = '0;
        model_block = chacha_stir(model_block);
      end
      ACT_MIX: begin
        model_block[key_slot] = model_block[key_slot] ^ dw;
        if (int'(model_mix_slot) + 1 >= MIX_SLOTS || lw) begin
          model_block = chacha_stir(model_block);
          model_mix_slot = '0;
        end else begin
          model_mix_slot = model_mix_slot + 3'd1;
        end
      end
      ACT_DRAW: begin
        // wrapping past word 3 stirs before the word is picked
        if (model_draw_slot == 2'd3) model_block = chacha_stir(model_block);
        model_draw_slot = model_draw_slot + 2'd1;
        drawn_words_due.push_back(model_block[{2'b00, model_draw_slot}]);
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // idle length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet) return 0;
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 120);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // one input item, held until the block takes it; valid stays up for back-to-back items
  task automatic send_item(input logic [1:0] act, input word_t dw, input logic lw);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    action    <= act;
    data_word <= dw;
    last_word <= lw;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    apply_item(act, dw, lw);
  endtask

  task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    if (idx <= REG_COUNTER_NONCE_HIGH) seed_regs[idx] = value;
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_regs(input logic [63:0] k0, input logic [63:0] k1,
                              input logic [63:0] k2, input logic [63:0] k3,
                              input logic [63:0] nonce, input logic [63:0] ctr_nonce);
    cfg_write(REG_KEY_PART_0, k0);
    cfg_write(REG_KEY_PART_1, k1);
    cfg_write(REG_KEY_PART_2, k2);
    cfg_write(REG_KEY_PART_3, k3);
    cfg_write(REG_NONCE_LOW, nonce);
    cfg_write(REG_COUNTER_NONCE_HIGH, ctr_nonce);
  endtask

  // stop sending, wait for every owed word, then let a trailing stir finish
  task automatic drain_and_settle();
    int waited;
    in_valid <= 1'b0;
    waited = 0;
    while (drawn_words_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (drawn_words_due.size() != 0) begin
      $error("random_word: expected %h, got nothing (%0d words never came)",
             drawn_words_due[0], drawn_words_due.size());
      mismatch_count++;
      drawn_words_due.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // well-formed traffic with random content, some noise mixed in
  task automatic random_burst(input int count);
    int sent;
    int kind;
    int len;
    logic [1:0] act;
    sent = 0;
    while (sent < count) begin
      kind = $urandom_range(0, 99);
      if (kind < 5) begin
        send_item(ACT_RESEED, $urandom, 1'($urandom_range(0, 1)));
        sent++;
      end else if (kind < 40) begin
        // entropy batch, usually closed by a last word, sometimes cut short early
        len = $urandom_range(1, 10);
        for (int j = 0; j < len; j++) begin
          send_item(ACT_MIX, $urandom, (j == len - 1) ? ($urandom_range(0, 3) != 0)
                                                      : ($urandom_range(0, 15) == 0));
        end
        sent += len;
      end else if (kind < 90) begin
        // run of draws, long enough to wrap the position now and then
        len = $urandom_range(1, 9);
        repeat (len) send_item(ACT_DRAW, $urandom, 1'($urandom_range(0, 1)));
        sent += len;
      end else begin
        act = 2'($urandom_range(0, 3));
        send_item(act, $urandom, 1'($urandom_range(0, 1)));
        if (act != ACT_UNUSED) sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // draws and mixes on the cleared block before any reseed
  task automatic test_before_seed();
    // the fourth draw wraps the position and stirs the all-zero block
    repeat (5) send_item(ACT_DRAW, $urandom, 1'($urandom_range(0, 1)));
    // unused action with every field bit set changes nothing
    send_item(ACT_UNUSED, '1, 1'b1);
    send_item(ACT_MIX, '1, 1'b0);
    send_item(ACT_MIX, '0, 1'b1);
    send_item(ACT_DRAW, '0, 1'b0);
  endtask

  // reseeds from all-zero and all-one registers, writes to indexes past the list
  task automatic test_register_extremes();
    drain_and_settle();
    program_regs('0, '0, '0, '0, '0, '0);
    send_item(ACT_RESEED, '0, 1'b0);
    repeat (2) send_item(ACT_DRAW, '1, 1'b1);
    drain_and_settle();
    program_regs('1, '1, '1, '1, '1, '1);
    send_item(ACT_RESEED, '1, 1'b1);
    repeat (2) send_item(ACT_DRAW, '0, 1'b0);
    drain_and_settle();
    // neither write may land in a real register
    cfg_write(REG_UNUSED_6, rand64());
    cfg_write(REG_UNUSED_7, '1);
    send_item(ACT_RESEED, $urandom, 1'b0);
    send_item(ACT_DRAW, $urandom, 1'b1);
  endtask

  // half-filled batch dropped by a reseed, batch of one closed by its last word
  task automatic test_mix_corners();
    send_item(ACT_MIX, '1, 1'b0);
    send_item(ACT_MIX, '0, 1'b0);
    send_item(ACT_MIX, $urandom, 1'b0);
    send_item(ACT_RESEED, $urandom, 1'b1);
    send_item(ACT_DRAW, $urandom, 1'b0);
    send_item(ACT_MIX, $urandom, 1'b1);
    send_item(ACT_DRAW, $urandom, 1'b0);
  endtask

  // several register settings, each followed by a long random stream
  task automatic test_random_phases();
    for (int phase = 0; phase < 6; phase++) begin
      drain_and_settle();
      case (phase)
        0: program_regs('0, '0, '0, '0, '0, '0);
        1: program_regs('1, '1, '1, '1, '1, '1);
        default: program_regs(rand64(), rand64(), rand64(), rand64(), rand64(), rand64());
      endcase
      // one phase runs flat out on both sides
      quiet = (phase == 3);
      send_item(ACT_RESEED, $urandom, 1'($urandom_range(0, 1)));
      random_burst(305);
      quiet = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  // stall pattern: bursts of random length between random open stretches
  initial begin
    int len;
    out_stall <= 1'b0;
    forever begin
      repeat ($urandom_range(1, 10)) @(posedge clk);
      len = idle_len();
      if (len > 0) begin
        out_stall <= 1'b1;
        repeat (len) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // every accepted word against the oldest owed one
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (drawn_words_due.size() == 0) begin
        $error("random_word: expected no result, got %h", random_word);
        mismatch_count++;
      end else begin
        if (random_word !== drawn_words_due[0]) begin
          $error("random_word: expected %h, got %h", drawn_words_due[0], random_word);
          mismatch_count++;
        end
        void'(drawn_words_due.pop_front());
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    for (int i = 0; i < 6; i++) seed_regs[i] = '0;
    model_block     = '0;
    model_mix_slot  = '0;
    model_draw_slot = '0;
    rst       <= 1'b1;
    cfg_wr_en <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    action    <= ACT_RESEED;
    data_word <= '0;
    last_word <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_before_seed();
    test_register_extremes();
    test_mix_corners();
    test_random_phases();

    drain_and_settle();
    if (mismatch_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // far beyond the slowest correct run
  initial begin
    #30_000_000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule
